// ===== rtl/core/pdwt_pkg.sv =====
// Shared types and constants for the pending/done work tracker.
`default_nettype none

package pdwt_pkg;

    localparam int WORD_W = 32;
    localparam int FUNC_W = 2;

    // Request function codes
    localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DONE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

    // Add of this value is ignored
    localparam logic [WORD_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [WORD_W-1:0] item_value;
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0] echo_value;
        logic              all_finished;
        logic [WORD_W-1:0] first_unfinished;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/pdwt_engine.sv =====
// Table memories and scan sequencer of the pending/done work tracker.
`default_nettype none

module pdwt_engine #(
    parameter int PENDING_DEPTH  = 1024,
    parameter int FINISHED_DEPTH = 2048
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire pdwt_pkg::req_t req,
    output logic               res_valid,
    input  wire logic          res_ready,
    output pdwt_pkg::res_t     res
);
    import pdwt_pkg::*;

    localparam int PAW = $clog2(PENDING_DEPTH);
    localparam int PCW = $clog2(PENDING_DEPTH + 1);
    localparam int FAW = $clog2(FINISHED_DEPTH);
    localparam int FCW = $clog2(FINISHED_DEPTH + 1);
    localparam logic [PCW-1:0] PEND_FULL = PCW'(PENDING_DEPTH);
    localparam logic [FCW-1:0] FIN_FULL  = FCW'(FINISHED_DEPTH);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_PSCAN  = 2'd1;
    localparam logic [1:0] ST_FSCAN  = 2'd2;
    localparam logic [1:0] ST_RESULT = 2'd3;

    // Pending entry: top bit marks a value already in the finished table
    logic [WORD_W:0]   pend_mem [PENDING_DEPTH];
    logic [WORD_W-1:0] fin_mem  [FINISHED_DEPTH];

    logic              pwr_en, prd_en, fwr_en, frd_en;
    logic [PAW-1:0]    pwr_addr, prd_addr;
    logic [WORD_W:0]   pwr_data;
    logic [FAW-1:0]    fwr_addr, frd_addr;
    logic [WORD_W-1:0] fwr_data;
    logic [WORD_W:0]   prd_data_reg;
    logic [WORD_W-1:0] frd_data_reg;

    logic [1:0]        state_reg, state_next;
    logic [FUNC_W-1:0] func_reg, func_next;
    logic [WORD_W-1:0] value_reg, value_next;
    logic              app_ok_reg, app_ok_next;
    logic              hit_reg, hit_next;
    logic [PAW-1:0]    slot_reg, slot_next;
    logic              slot_new_reg, slot_new_next;
    logic [PCW-1:0]    hw_reg, hw_next;
    logic [FCW-1:0]    fcnt_reg, fcnt_next;
    logic [PCW-1:0]    pidx_reg, pidx_next;
    logic              pdv_reg, pdv_next;
    logic [PAW-1:0]    pdidx_reg, pdidx_next;
    logic [FCW-1:0]    fidx_reg, fidx_next;
    logic              fdv_reg, fdv_next;
    logic              all_reg, all_next;
    logic [WORD_W-1:0] first_reg, first_next;

    logic              stop;
    logic [WORD_W-1:0] pq_value;
    logic              pq_flag;

    // Pending memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (pwr_en) begin
            pend_mem[pwr_addr] <= pwr_data;
        end
        if (prd_en) begin
            prd_data_reg <= pend_mem[prd_addr];
        end
    end

    // Finished memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (fwr_en) begin
            fin_mem[fwr_addr] <= fwr_data;
        end
        if (frd_en) begin
            frd_data_reg <= fin_mem[frd_addr];
        end
    end

    assign pq_value = prd_data_reg[WORD_W-1:0];
    assign pq_flag  = prd_data_reg[WORD_W];

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        func_next     = func_reg;
        value_next    = value_reg;
        app_ok_next   = app_ok_reg;
        hit_next      = hit_reg;
        slot_next     = slot_reg;
        slot_new_next = slot_new_reg;
        hw_next       = hw_reg;
        fcnt_next     = fcnt_reg;
        pidx_next     = pidx_reg;
        pdv_next      = 1'b0;
        pdidx_next    = pdidx_reg;
        fidx_next     = fidx_reg;
        fdv_next      = 1'b0;
        all_next      = all_reg;
        first_next    = first_reg;
        stop          = 1'b0;

        pwr_en   = 1'b0;
        pwr_addr = pdidx_reg;
        pwr_data = '0;
        prd_en   = 1'b0;
        prd_addr = pidx_reg[PAW-1:0];
        fwr_en   = 1'b0;
        fwr_addr = fcnt_reg[FAW-1:0];
        fwr_data = req.item_value;
        frd_en   = 1'b0;
        frd_addr = fidx_reg[FAW-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (req_valid) begin
                    func_next   = req.func;
                    value_next  = req.item_value;
                    all_next    = (req.func == FUNC_QUERY);
                    first_next  = '0;
                    hit_next    = 1'b0;
                    app_ok_next = 1'b0;
                    pidx_next   = '0;
                    fidx_next   = '0;
                    unique case (req.func)
                        FUNC_ADD: begin
                            // zero and all ones never change the tables
                            if (req.item_value == '0 || req.item_value == ALL_ONES) begin
                                state_next = ST_RESULT;
                            end else begin
                                state_next = ST_PSCAN;
                            end
                        end
                        FUNC_DONE: begin
                            if (req.item_value == '0) begin
                                state_next = ST_RESULT;
                            end else begin
                                // append to the finished table if room is left
                                if (fcnt_reg != FIN_FULL) begin
                                    fwr_en      = 1'b1;
                                    fcnt_next   = fcnt_reg + FCW'(1);
                                    app_ok_next = 1'b1;
                                end
                                state_next = ST_PSCAN;
                            end
                        end
                        FUNC_QUERY: begin
                            state_next = ST_PSCAN;
                        end
                        default: begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end

            ST_PSCAN: begin
                // act on the word read in the previous cycle
                if (pdv_reg) begin
                    case (func_reg)
                        FUNC_ADD: begin
                            if (pq_value == '0) begin
                                slot_next     = pdidx_reg;
                                slot_new_next = 1'b0;
                                stop          = 1'b1;
                                state_next    = ST_FSCAN;
                            end
                        end
                        FUNC_DONE: begin
                            if (pq_value == value_reg) begin
                                if (!hit_reg) begin
                                    pwr_en   = 1'b1;
                                    pwr_data = '0;
                                    hit_next = 1'b1;
                                end else if (app_ok_reg) begin
                                    pwr_en   = 1'b1;
                                    pwr_data = {1'b1, value_reg};
                                end
                            end
                        end
                        FUNC_QUERY: begin
                            if (pq_value != '0 && !pq_flag) begin
                                all_next   = 1'b0;
                                first_next = pq_value;
                                stop       = 1'b1;
                                state_next = ST_RESULT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                // advance the read pointer up to the high-water mark
                if (!stop) begin
                    if (pidx_reg != hw_reg) begin
                        prd_en     = 1'b1;
                        pidx_next  = pidx_reg + PCW'(1);
                        pdv_next   = 1'b1;
                        pdidx_next = pidx_reg[PAW-1:0];
                    end else if (!pdv_reg) begin
                        if (func_reg == FUNC_ADD && hw_reg != PEND_FULL) begin
                            slot_next     = hw_reg[PAW-1:0];
                            slot_new_next = 1'b1;
                            state_next    = ST_FSCAN;
                        end else begin
                            state_next = ST_RESULT;
                        end
                    end
                end
            end

            ST_FSCAN: begin
                if (fdv_reg && frd_data_reg == value_reg) begin
                    // already finished: drop the add
                    state_next = ST_RESULT;
                end else if (fidx_reg != fcnt_reg) begin
                    frd_en    = 1'b1;
                    fidx_next = fidx_reg + FCW'(1);
                    fdv_next  = 1'b1;
                end else if (!fdv_reg) begin
                    pwr_en   = 1'b1;
                    pwr_addr = slot_reg;
                    pwr_data = {1'b0, value_reg};
                    if (slot_new_reg) begin
                        hw_next = hw_reg + PCW'(1);
                    end
                    state_next = ST_RESULT;
                end
            end

            ST_RESULT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            hw_reg    <= '0;
            fcnt_reg  <= '0;
            pdv_reg   <= 1'b0;
            fdv_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            hw_reg    <= hw_next;
            fcnt_reg  <= fcnt_next;
            pdv_reg   <= pdv_next;
            fdv_reg   <= fdv_next;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        func_reg     <= func_next;
        value_reg    <= value_next;
        app_ok_reg   <= app_ok_next;
        hit_reg      <= hit_next;
        slot_reg     <= slot_next;
        slot_new_reg <= slot_new_next;
        pidx_reg     <= pidx_next;
        pdidx_reg    <= pdidx_next;
        fidx_reg     <= fidx_next;
        all_reg      <= all_next;
        first_reg    <= first_next;
    end

    assign req_ready            = (state_reg == ST_IDLE);
    assign res_valid            = (state_reg == ST_RESULT);
    assign res.echo_value       = value_reg;
    assign res.all_finished     = all_reg;
    assign res.first_unfinished = first_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pending_done_work_tracker_top.sv =====
// Pending/done work tracker: one word in, one result word out.
//
// Input channel (s_): s_func selects add (0), done (1) or query (2), s_item_value
// carries the work identifier. Output channel (m_): the identifier echoed back,
// plus all_finished and first_unfinished, both zero for anything but a query.
// Exactly one result word leaves for every input word, in order.
// Each word is worked on alone: the sequencer reads one memory entry per cycle.
// A query or done scans the pending memory up to its high-water mark; an add
// scans pending for a free slot and, if one is found, then the filled part of
// the finished memory. An add of zero or all ones, a done of zero and an unused
// code skip both scans. The next input word is taken the cycle after a result
// moves into the output register.
// The output register holds a result while m_ready is low; the next input word
// is then still accepted and worked on, and waits until the register frees.
// Reset (aresetn low, synchronous) empties both tables at once: the pending
// high-water mark and the finished fill count return to zero, no clearing pass.
`default_nettype none

module pending_done_work_tracker_top #(
    parameter int PENDING_DEPTH  = 1024,
    parameter int FINISHED_DEPTH = 2048
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [pdwt_pkg::FUNC_W-1:0] s_func,
    input  wire logic [pdwt_pkg::WORD_W-1:0] s_item_value,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [pdwt_pkg::WORD_W-1:0]      m_echo_value,
    output logic                             m_all_finished,
    output logic [pdwt_pkg::WORD_W-1:0]      m_first_unfinished
);
    import pdwt_pkg::*;

    req_t req;
    res_t res;
    logic res_valid;
    logic res_ready;
    logic m_valid_reg, m_valid_next;
    res_t out_reg;

    assign req.func       = s_func;
    assign req.item_value = s_item_value;

    pdwt_engine #(
        .PENDING_DEPTH (PENDING_DEPTH),
        .FINISHED_DEPTH(FINISHED_DEPTH)
    ) u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req_valid(s_valid),
        .req_ready(s_ready),
        .req      (req),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res)
    );

    // Take a result whenever the output register is free or draining
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold the payload until the receiver takes it
    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_echo_value       = out_reg.echo_value;
    assign m_all_finished     = out_reg.all_finished;
    assign m_first_unfinished = out_reg.first_unfinished;

endmodule

`default_nettype wire

// ===== rtl/core/pdwt_checker.sv =====
// Port-level checks for the work tracker top level, with its bind.
`default_nettype none

module pdwt_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_valid,
    input wire logic                        s_ready,
    input wire logic [pdwt_pkg::FUNC_W-1:0] s_func,
    input wire logic [pdwt_pkg::WORD_W-1:0] s_item_value,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic [pdwt_pkg::WORD_W-1:0] m_echo_value,
    input wire logic                        m_all_finished,
    input wire logic [pdwt_pkg::WORD_W-1:0] m_first_unfinished
);
    import pdwt_pkg::*;

    // Reset empties the output register
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // One word at a time: an accepted word closes the input until it is done
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a word is in work");

    // A waiting input word holds until it is taken
    a_input_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && !s_ready) |=> (s_valid && $stable(s_func)
            && $stable(s_item_value)))
        else $error("input word changed while waiting");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_echo_value)
            && $stable(m_all_finished) && $stable(m_first_unfinished)))
        else $error("result changed while stalled");

    // All finished and an unfinished value exclude each other
    a_status_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_all_finished && m_first_unfinished != '0))
        else $error("all_finished with a nonzero first_unfinished");

endmodule

bind pending_done_work_tracker_top pdwt_checker u_pdwt_checker (.*);

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the pending/done work tracker top level.
module tb;

    import pdwt_pkg::*;

    // Shrink the tables so that the full cases are reached within a short run
    localparam int PEND_SLOTS    = 8;
    localparam int DONE_SLOTS    = 20;
    localparam int RANDOM_WORDS  = 115;
    localparam int STALL_LIMIT   = 3000;
    localparam int LONG_HOLD     = 400;
    localparam int HOLD_AFTER    = 70;
    localparam int DRAIN_CYCLES  = PEND_SLOTS + DONE_SLOTS + 16;

    // Spare function code: the block answers with the echo only
    localparam logic [FUNC_W-1:0] FUNC_IDLE = 2'd3;

    localparam logic TYPED     = 1'b1;
    localparam logic PREDICTED = 1'b0;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [WORD_W-1:0] value;
        logic              typed;
        logic              want_all;
        logic [WORD_W-1:0] want_first;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 25;

    // Directed words: the status columns only count where typed is set
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{FUNC_QUERY, 32'h0000_0000, TYPED,     1'b1, 32'h0000_0000},
        '{FUNC_IDLE,  32'hFFFF_FFFF, TYPED,     1'b0, 32'h0000_0000},
        '{FUNC_ADD,   32'hFFFF_FFFF, TYPED,     1'b0, 32'h0000_0000},
        '{FUNC_QUERY, 32'h0000_0000, TYPED,     1'b1, 32'h0000_0000},
        '{FUNC_ADD,   32'h0000_0000, PREDICTED, 1'b0, 32'h0000_0000},
        '{FUNC_ADD,   32'h0000_0005, PREDICTED, 1'b0, 32'h0000_0000},
        '{FUNC_QUERY, 32'h0000_0000, TYPED,     1'b0, 32'h0000_0005},
        '{FUNC_ADD,   32'h0000_0005, PREDICTED, 1'b0, 32'h0000_0000},
        '{FUNC_DONE,  32'h0000_0005, PREDICTED, 1'b0, 32'h0000_0000},
        '{FUNC_QUERY, 32'h0000_1234, TYPED,     1'b1, 32'h0000_0000},
        '{FUNC_ADD,   32'h0000_0005, PREDICTED, 1'b0, 32'h0000_0000},
        '{FUNC_QUERY, 32'h0000_0000, TYPED,     1'b1, 32'h0000_0000},
        '{FUNC_DONE,  32'h0000_0007, PREDICTED, 1'b0, 32'h0000_0000},
        '{FUNC_ADD,   32'h8000_0001, PREDICTED, 1'b0, 32'h0000_0000},
        '{FUNC_ADD,   32'h7FFF_FFFE, PREDICTED, 1'b0, 32'h0000_0000},
        '{FUNC_DONE,  32'hFFFF_FFFF, PREDICTED, 1'b0, 32'h0000_0000},
        '{FUNC_ADD,   32'h0000_0001, PREDICTED, 1'b0, 32'h0000_0000},
        '{FUNC_ADD,   32'h0000_0002, PREDICTED, 1'b0, 32'h0000_0000},
        '{FUNC_ADD,   32'h0000_0003, PREDICTED, 1'b0, 32'h0000_0000},
        '{FUNC_ADD,   32'h0000_0004, PREDICTED, 1'b0, 32'h0000_0000},
        '{FUNC_ADD,   32'h0000_0006, PREDICTED, 1'b0, 32'h0000_0000},
        '{FUNC_ADD,   32'h0000_0009, PREDICTED, 1'b0, 32'h0000_0000},
        '{FUNC_DONE,  32'h0000_0000, PREDICTED, 1'b0, 32'h0000_0000},
        '{FUNC_DONE,  32'h8000_0001, PREDICTED, 1'b0, 32'h0000_0000},
        '{FUNC_QUERY, 32'h0000_0000, PREDICTED, 1'b0, 32'h0000_0000}
    };

    logic              aclk         = 1'b0;
    logic              aresetn      = 1'b0;
    logic              s_valid      = 1'b0;
    logic [FUNC_W-1:0] s_func       = FUNC_ADD;
    logic [WORD_W-1:0] s_item_value = '0;
    logic              m_ready      = 1'b0;
    logic              s_ready;
    logic              m_valid;
    logic [WORD_W-1:0] m_echo_value;
    logic              m_all_finished;
    logic [WORD_W-1:0] m_first_unfinished;

    // Mirror of the two tables
    logic [WORD_W-1:0] open_work [PEND_SLOTS];
    logic [WORD_W-1:0] retired_work [DONE_SLOTS];

    res_t expected_results [$];
    int   mismatches  = 0;
    int   idle_cycles = 0;

    always #4 aclk = ~aclk;

    pending_done_work_tracker_top #(
        .PENDING_DEPTH  (PEND_SLOTS),
        .FINISHED_DEPTH (DONE_SLOTS)
    ) dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_func             (s_func),
        .s_item_value       (s_item_value),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_echo_value       (m_echo_value),
        .m_all_finished     (m_all_finished),
        .m_first_unfinished (m_first_unfinished)
    );

    function automatic bit is_retired(logic [WORD_W-1:0] v);
        for (int k = 0; k < DONE_SLOTS; k++) begin
            if (retired_work[k] == v) return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advance the mirrored tables by one word and return its status
    function automatic res_t track_word(logic [FUNC_W-1:0] f, logic [WORD_W-1:0] v);
        res_t r;
        bit   hit;
        r.echo_value       = v;
        r.all_finished     = 1'b0;
        r.first_unfinished = '0;
        hit = 1'b0;
        case (f)
            FUNC_ADD: begin
                if (v != ALL_ONES) begin
                    for (int k = 0; k < PEND_SLOTS; k++) begin
                        if (!hit && open_work[k] == '0) begin
                            hit = 1'b1;
                            if (!is_retired(v)) open_work[k] = v;
                        end
                    end
                end
            end
            FUNC_DONE: begin
                for (int k = 0; k < PEND_SLOTS; k++) begin
                    if (!hit && open_work[k] == v) begin
                        hit = 1'b1;
                        open_work[k] = '0;
                    end
                end
                hit = 1'b0;
                for (int k = 0; k < DONE_SLOTS; k++) begin
                    if (!hit && retired_work[k] == '0) begin
                        hit = 1'b1;
                        retired_work[k] = v;
                    end
                end
            end
            FUNC_QUERY: begin
                r.all_finished = 1'b1;
                for (int k = 0; k < PEND_SLOTS; k++) begin
                    if (!hit && open_work[k] != '0 && !is_retired(open_work[k])) begin
                        hit = 1'b1;
                        r.all_finished     = 1'b0;
                        r.first_unfinished = open_work[k];
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Gap before a word: stretches of back-to-back words between random gaps
    function automatic int draw_wait(int idx);
        if ((idx / 25) % 3 == 2) return 0;
        return $urandom_range(0, 13);
    endfunction

    function automatic logic [FUNC_W-1:0] pick_func();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 45) return FUNC_ADD;
        if (sel < 67) return FUNC_DONE;
        if (sel < 92) return FUNC_QUERY;
        return FUNC_IDLE;
    endfunction

    // Mostly a small pool of identifiers so that adds, dones and queries meet
    function automatic logic [WORD_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60) return WORD_W'($urandom_range(1, 12));
        if (sel < 70) return '0;
        if (sel < 80) return ALL_ONES;
        return $urandom;
    endfunction

    // Offer one word, hold it until taken, then queue what it must return
    task automatic send_word(stim_row_t row, int idx);
        int   gap;
        res_t want;
        gap = draw_wait(idx);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_func       <= row.func;
        s_item_value <= row.value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        want = track_word(row.func, row.value);
        if (row.typed) begin
            want.all_finished     = row.want_all;
            want.first_unfinished = row.want_first;
        end
        expected_results.push_back(want);
    endtask

    // Stimulus: reset, directed table, random words, drain
    initial begin
        stim_row_t row;
        for (int k = 0; k < PEND_SLOTS; k++) open_work[k] = '0;
        for (int k = 0; k < DONE_SLOTS; k++) retired_work[k] = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int i = 0; i < DIRECTED_ROWS; i++) send_word(directed_rows[i], i);
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            row.func       = pick_func();
            row.value      = pick_value();
            row.typed      = PREDICTED;
            row.want_all   = 1'b0;
            row.want_first = '0;
            send_word(row, DIRECTED_ROWS + n);
        end
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Result side: random back-pressure, one long hold to fill the block up
    initial begin
        int  gap;
        int  taken;
        bit  held;
        taken = 0;
        held  = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!held && taken >= HOLD_AFTER) begin
                held = 1'b1;
                gap  = LONG_HOLD;
            end else begin
                gap = draw_wait(taken);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            taken++;
        end
    end

    // Compare each result word against the oldest expectation
    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result word, expected none, got echo %h",
                         $time, m_echo_value);
            end else begin
                want = expected_results.pop_front();
                if (m_echo_value !== want.echo_value) begin
                    mismatches++;
                    $display("%0t: echo_value mismatch, expected %h, got %h",
                             $time, want.echo_value, m_echo_value);
                end
                if (m_all_finished !== want.all_finished) begin
                    mismatches++;
                    $display("%0t: all_finished mismatch, expected %b, got %b",
                             $time, want.all_finished, m_all_finished);
                end
                if (m_first_unfinished !== want.first_unfinished) begin
                    mismatches++;
                    $display("%0t: first_unfinished mismatch, expected %h, got %h",
                             $time, want.first_unfinished, m_first_unfinished);
                end
            end
        end
    end

    // Watchdog: end the run when no word moves on either side for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
                $display("FAILURE");
                $finish;
            end
        end
    end

endmodule

// ===== pending_done_work_tracker_top.f =====
rtl/core/pdwt_pkg.sv
rtl/core/pdwt_engine.sv
rtl/core/pending_done_work_tracker_top.sv
rtl/core/pdwt_checker.sv
tb/tb.sv
